// ----- rtl/fdcrc_pkg.sv -----
// Shared constants and CRC16-CCITT-FALSE helpers for the frame deframer.
package fdcrc_pkg;

   localparam int BYTE_W = 8;
   localparam int CRC_W  = 16;
   localparam int KIND_W = 2;
   localparam int PH_W   = 3;

   localparam logic [CRC_W-1:0]  CRC_SEED         = 16'hFFFF;
   localparam logic [BYTE_W-1:0] SYNC_RESET       = 8'hFE;
   localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'hFF;

   localparam logic [0:0] CSR_SYNC_BYTE   = 1'b0;
   localparam logic [0:0] CSR_MAX_PAYLOAD = 1'b1;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CRC_W-1:0]  crc_type;

   function automatic crc_type nib_term(input logic [3:0] k);
      crc_type r;
      case (k)
         4'h0: r = 16'h0000;
         4'h1: r = 16'h1021;
         4'h2: r = 16'h2042;
         4'h3: r = 16'h3063;
         4'h4: r = 16'h4084;
         4'h5: r = 16'h50A5;
         4'h6: r = 16'h60C6;
         4'h7: r = 16'h70E7;
         4'h8: r = 16'h8108;
         4'h9: r = 16'h9129;
         4'hA: r = 16'hA14A;
         4'hB: r = 16'hB16B;
         4'hC: r = 16'hC18C;
         4'hD: r = 16'hD1AD;
         4'hE: r = 16'hE1CE;
         4'hF: r = 16'hF1EF;
         default: r = 16'h0000;
      endcase
      return r;
   endfunction

   function automatic crc_type crc_byte(input crc_type crc, input byte_type b);
      crc_type c1;
      crc_type c2;
      c1 = {crc[11:0], 4'h0} ^ nib_term(crc[15:12] ^ b[7:4]);
      c2 = {c1[11:0], 4'h0} ^ nib_term(c1[15:12] ^ b[3:0]);
      return c2;
   endfunction

endpackage

// ----- rtl/frame_deframer_crc16_unit.sv -----
// Length-prefixed frame parser with running CRC16-CCITT-FALSE check.
//
// Channel  Dir  Beat contents (low bit first)
// req      in   tdata: rx_byte[7:0]
// rsp      out  tdata: data_byte, byte_index, msg_id, msg_len; tuser: event_kind
// csr      in   csr_index selects sync_byte (0) or max_payload (1)
//
// One byte is taken per cycle; its result is registered at the accepting edge and valid next cycle.
// The parse step sits between the phase registers and the output register; a two-nibble
// CRC update feeds the CRC register. Reset is synchronous and returns the parser to sync hunt.
// A stalled output blocks input only while the output register is full and not taken.
module frame_deframer_crc16_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // data_byte, byte_index, msg_id, msg_len
   output logic [1:0]  rsp_tuser,   // event_kind
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam logic [2:0] PH_SYNC    = 3'd0;
   localparam logic [2:0] PH_ID      = 3'd1;
   localparam logic [2:0] PH_LEN     = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CRC_LO  = 3'd4;
   localparam logic [2:0] PH_CRC_HI  = 3'd5;

   localparam logic [1:0] EV_DATA   = 2'd0;
   localparam logic [1:0] EV_GOOD   = 2'd1;
   localparam logic [1:0] EV_BADCRC = 2'd2;
   localparam logic [1:0] EV_BADLEN = 2'd3;

   logic [2:0]                phase_ff, phase_in;
   fdcrc_pkg::byte_type       id_ff, id_in;
   fdcrc_pkg::byte_type       len_ff, len_in;
   fdcrc_pkg::byte_type       fill_ff, fill_in;
   fdcrc_pkg::crc_type        crc_ff, crc_in;
   fdcrc_pkg::byte_type       crc_lo_ff, crc_lo_in;
   fdcrc_pkg::byte_type       sync_ff, maxp_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                kind_ff, kind_in;
   logic [31:0]               data_ff, data_in;
   logic                      ev_fire;

   logic                      accept;
   fdcrc_pkg::byte_type       rx;
   fdcrc_pkg::crc_type        crc_step;
   logic [8:0]                fill_next;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rx         = req_tdata;
   assign crc_step   = fdcrc_pkg::crc_byte(crc_ff, rx);
   assign fill_next  = {1'b0, fill_ff} + 9'd1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;

   always_comb begin
      phase_in  = phase_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      fill_in   = fill_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      ev_fire   = 1'b0;
      kind_in   = kind_ff;
      data_in   = data_ff;
      if (accept) begin
         case (phase_ff)
            PH_SYNC: begin
               if (rx == sync_ff) begin
                  crc_in   = fdcrc_pkg::CRC_SEED;
                  phase_in = PH_ID;
               end
            end
            PH_ID: begin
               id_in    = rx;
               crc_in   = crc_step;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (rx > maxp_ff) begin
                  phase_in = PH_SYNC;
                  ev_fire  = 1'b1;
                  kind_in  = EV_BADLEN;
                  data_in  = {rx, id_ff, 16'h0000};
               end else begin
                  len_in   = rx;
                  fill_in  = '0;
                  crc_in   = crc_step;
                  phase_in = (rx != '0) ? PH_PAYLOAD : PH_CRC_LO;
               end
            end
            PH_PAYLOAD: begin
               crc_in  = crc_step;
               fill_in = fill_next[7:0];
               if (fill_next >= {1'b0, len_ff}) begin
                  phase_in = PH_CRC_LO;
               end
               ev_fire = 1'b1;
               kind_in = EV_DATA;
               data_in = {len_ff, id_ff, fill_ff, rx};
            end
            PH_CRC_LO: begin
               crc_lo_in = rx;
               phase_in  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               phase_in = PH_SYNC;
               ev_fire  = 1'b1;
               kind_in  = ({rx, crc_lo_ff} == crc_ff) ? EV_GOOD : EV_BADCRC;
               data_in  = {len_ff, id_ff, 16'h0000};
            end
            default: begin
               phase_in = PH_SYNC;
            end
         endcase
      end
      if (ev_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC;
         id_ff        <= '0;
         len_ff       <= '0;
         fill_ff      <= '0;
         crc_ff       <= fdcrc_pkg::CRC_SEED;
         crc_lo_ff    <= '0;
         sync_ff      <= fdcrc_pkg::SYNC_RESET;
         maxp_ff      <= fdcrc_pkg::MAX_PAYLOAD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         id_ff        <= id_in;
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         crc_ff       <= crc_in;
         crc_lo_ff    <= crc_lo_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               fdcrc_pkg::CSR_SYNC_BYTE:   sync_ff <= csr_wdata;
               fdcrc_pkg::CSR_MAX_PAYLOAD: maxp_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ev_fire) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
      end
   end

   a_payload_emits: assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == PH_PAYLOAD) |=> rsp_valid_ff && (kind_ff == EV_DATA))
      else $error("payload beat gave no data event");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (fill_ff < len_ff))
      else $error("fill count reached frame length inside payload");

   a_crc_hi_resync: assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == PH_CRC_HI) |=> (phase_ff == PH_SYNC) && rsp_valid_ff)
      else $error("closing CRC beat did not end the frame");

   a_index_below_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff == EV_DATA) |-> (data_ff[15:8] < data_ff[31:24]))
      else $error("payload index not below frame length");

   a_sync_silent: assert property (@(posedge clock) disable iff (reset)
      accept && ((phase_ff == PH_SYNC) || (phase_ff == PH_ID)) |-> !ev_fire)
      else $error("event raised during sync hunt or id beat");

endmodule

// ----- tb/tb_deframer_pkg.sv -----
// Event types, bitwise CRC16 and the frame parser scoreboard for the deframer bench.
package tb_deframer_pkg;
   import fdcrc_pkg::*;

   localparam crc_type CRC_POLY = 16'h1021;

   typedef enum logic [KIND_W-1:0] {
      EV_PAYLOAD_BYTE,
      EV_FRAME_GOOD,
      EV_CRC_MISMATCH,
      EV_LEN_TOO_LARGE
   } event_kind_e;

   typedef enum logic [PH_W-1:0] {
      ST_HUNT,
      ST_ID,
      ST_LEN,
      ST_PAYLOAD,
      ST_CRC_LO,
      ST_CRC_HI
   } parse_state_e;

   typedef struct packed {
      event_kind_e kind;
      byte_type    data;
      byte_type    index;
      byte_type    id;
      byte_type    len;
   } frame_event_t;

   function automatic crc_type crc_ccitt_step(input crc_type crc, input byte_type b);
      crc_type c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   class deframer_scoreboard;
      byte_type     sync_val;
      byte_type     max_len;
      parse_state_e state;
      byte_type     cur_id;
      byte_type     cur_len;
      byte_type     fill;
      byte_type     crc_lo;
      crc_type      crc;
      frame_event_t due_events[$];
      int           errors;

      function new();
         sync_val = SYNC_RESET;
         max_len  = MAX_PAYLOAD_RESET;
         state    = ST_HUNT;
         cur_id   = '0;
         cur_len  = '0;
         fill     = '0;
         crc_lo   = '0;
         crc      = CRC_SEED;
         errors   = 0;
      endfunction

      function void write_reg(input logic [0:0] idx, input byte_type v);
         if (idx == CSR_SYNC_BYTE) begin
            sync_val = v;
         end else if (idx == CSR_MAX_PAYLOAD) begin
            max_len = v;
         end
      endfunction

      function int pending();
         return due_events.size();
      endfunction

      function void log_event(input event_kind_e kind, input byte_type data,
                              input byte_type index, input byte_type id, input byte_type len);
         frame_event_t ev;
         ev.kind  = kind;
         ev.data  = data;
         ev.index = index;
         ev.id    = id;
         ev.len   = len;
         due_events.push_back(ev);
      endfunction

      function void note_rx_byte(input byte_type b);
         case (state)
            ST_HUNT: begin
               if (b == sync_val) begin
                  crc   = CRC_SEED;
                  state = ST_ID;
               end
            end
            ST_ID: begin
               cur_id = b;
               crc    = crc_ccitt_step(crc, b);
               state  = ST_LEN;
            end
            ST_LEN: begin
               if (b > max_len) begin
                  state = ST_HUNT;
                  log_event(EV_LEN_TOO_LARGE, '0, '0, cur_id, b);
               end else begin
                  cur_len = b;
                  fill    = '0;
                  crc     = crc_ccitt_step(crc, b);
                  state   = (b != 0) ? ST_PAYLOAD : ST_CRC_LO;
               end
            end
            ST_PAYLOAD: begin
               log_event(EV_PAYLOAD_BYTE, b, fill, cur_id, cur_len);
               crc = crc_ccitt_step(crc, b);
               if (int'(fill) + 1 >= int'(cur_len)) begin
                  state = ST_CRC_LO;
               end
               fill = fill + 8'd1;
            end
            ST_CRC_LO: begin
               crc_lo = b;
               state  = ST_CRC_HI;
            end
            ST_CRC_HI: begin
               log_event(({b, crc_lo} == crc) ? EV_FRAME_GOOD : EV_CRC_MISMATCH,
                         '0, '0, cur_id, cur_len);
               state = ST_HUNT;
            end
            default: begin
               state = ST_HUNT;
            end
         endcase
      endfunction

      task report(input string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_event(input logic [KIND_W-1:0] kind, input logic [31:0] word);
         frame_event_t due;
         logic [7:0]   got[5];
         logic [7:0]   want[5];
         string        names[5];
         if (due_events.size() == 0) begin
            report($sformatf("unexpected event kind %0d tdata %08h", kind, word));
            return;
         end
         due   = due_events.pop_front();
         names = '{"event_kind", "data_byte", "byte_index", "msg_id", "msg_len"};
         got   = '{{6'd0, kind}, word[7:0], word[15:8], word[23:16], word[31:24]};
         want  = '{{6'd0, due.kind}, due.data, due.index, due.id, due.len};
         for (int f = 0; f < 5; f++) begin
            if (got[f] !== want[f]) begin
               report($sformatf("%s got %02h want %02h (id %02h len %02h)",
                                names[f], got[f], want[f], due.id, due.len));
            end
         end
      endtask
   endclass

endpackage

// ----- tb/tb_top.sv -----
// Top-level bench: drives framed byte streams into the deframer and checks its events.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fdcrc_pkg::*;
   import tb_deframer_pkg::*;

   localparam int IDLE_GAP    = 4;
   localparam int QUIET_LIMIT = 2000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we      = 1'b0;
   logic [0:0]  csr_index   = CSR_SYNC_BYTE;
   logic [7:0]  csr_wdata   = 8'h00;

   bit                 idle_on = 1'b1;
   int                 quiet_cycles = 0;
   deframer_scoreboard sb;

   frame_deframer_crc16_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= !idle_on || ($urandom_range(99) >= 7);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_rx_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_event(rsp_tuser, rsp_tdata);
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("[frame_deframer_crc16_unit] ERROR");
         $finish;
      end
   end

   task automatic send_byte(input byte_type b);
      while (idle_on && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input byte_type v);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_frame(input byte_type id, input byte_type body[$], input bit bad_crc,
                             input int cut);
      byte_type q[$];
      crc_type  crc;
      int       n;
      q = {sb.sync_val, id, byte_type'(body.size())};
      foreach (body[i]) q.push_back(body[i]);
      crc = CRC_SEED;
      for (int i = 1; i < q.size(); i++) crc = crc_ccitt_step(crc, q[i]);
      q.push_back(crc[7:0]);
      q.push_back(crc[15:8]);
      if (bad_crc) begin
         q[$urandom_range(q.size() - 1, 3)] ^= 8'h01 << $urandom_range(7);
      end
      n = (cut < 0) ? q.size() : cut;
      for (int i = 0; i < n; i++) send_byte(q[i]);
   endtask

   task automatic run_traffic(input int n_bytes);
      byte_type body[$];
      byte_type id;
      int       sent;
      int       len;
      int       r;
      int       cut;
      int       noise;
      sent = 0;
      while (sent < n_bytes) begin
         r  = $urandom_range(99);
         id = byte_type'($urandom);
         if (r < 8) begin
            noise = $urandom_range(4, 1);
            repeat (noise) send_byte(byte_type'($urandom));
            sent += noise;
         end else if (r < 16 && sb.max_len != 8'hFF) begin
            send_byte(sb.sync_val);
            send_byte(id);
            send_byte(byte_type'($urandom_range(255, sb.max_len + 1)));
            sent += 3;
         end else begin
            if ($urandom_range(99) < 10) begin
               len = $urandom_range(sb.max_len);
            end else begin
               len = $urandom_range((sb.max_len < 16) ? sb.max_len : 16);
            end
            body.delete();
            repeat (len) body.push_back(byte_type'($urandom));
            cut = ($urandom_range(99) < 8) ? $urandom_range(len + 4, 1) : -1;
            send_frame(id, body, $urandom_range(99) < 15, cut);
            sent += (cut < 0) ? len + 5 : cut;
         end
      end
   endtask

   initial begin
      byte_type body[$];
      sb = new();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // hunt noise, zero length, sync value inside payload, oversize length, length at limit
      send_byte(8'h00);
      send_byte(8'hFF);
      body.delete();
      send_frame(8'hFF, body, 1'b0, -1);
      body = {8'hFE, 8'h00, 8'hFF};
      send_frame(8'h00, body, 1'b1, -1);
      write_csr(CSR_MAX_PAYLOAD, 8'd2);
      send_byte(SYNC_RESET);
      send_byte(8'h5A);
      send_byte(8'hFF);
      body = {8'h80, 8'h7F};
      send_frame(8'hA5, body, 1'b0, -1);

      write_csr(CSR_SYNC_BYTE, 8'h00);
      write_csr(CSR_MAX_PAYLOAD, 8'h00);
      run_traffic(300);

      write_csr(CSR_SYNC_BYTE, 8'hFF);
      write_csr(CSR_MAX_PAYLOAD, 8'hFF);
      run_traffic(500);

      write_csr(CSR_SYNC_BYTE, byte_type'($urandom));
      write_csr(CSR_MAX_PAYLOAD, byte_type'($urandom_range(40, 1)));
      idle_on = 1'b0;
      run_traffic(400);
      idle_on = 1'b1;

      write_csr(CSR_SYNC_BYTE, 8'h7E);
      write_csr(CSR_MAX_PAYLOAD, 8'd12);
      run_traffic(400);

      write_csr(CSR_SYNC_BYTE, SYNC_RESET);
      write_csr(CSR_MAX_PAYLOAD, MAX_PAYLOAD_RESET);
      run_traffic(350);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[frame_deframer_crc16_unit] OK");
      end else begin
         $display("[frame_deframer_crc16_unit] ERROR");
      end
      $finish;
   end

endmodule
